// ----- rtl/core/vl2n_pkg.sv -----
// ----------------------------------------------------------------------------
// vl2n_pkg
// shared constants and types for the vector l2 normalize unit
// ----------------------------------------------------------------------------
`default_nettype none
package vl2n_pkg;
  localparam int VectorLen  = 64;
  localparam int StoreDepth = 64;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int CountW     = AddrW + 1;
  localparam int ElemW      = 16;
  localparam int SumW       = 48;
  localparam int RadW       = 64;
  localparam int RootW      = 32;
  localparam int DenW       = 33;
  localparam int ScaleW     = 25;
  localparam logic [DenW-1:0] EpsQ16 = DenW'(104858);

  typedef struct packed {
    logic start;
    logic [SumW-1:0] sum;
  } calc_req_t;

  typedef struct packed {
    logic done;
    logic [ScaleW-1:0] scale;
  } calc_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/vl2n_scale_calc.sv -----
// ----------------------------------------------------------------------------
// vl2n_scale_calc
// scale = floor(2^40 / (isqrt(sum << 16) + eps)), bit-serial root then divide
// ----------------------------------------------------------------------------
`default_nettype none
module vl2n_scale_calc (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vl2n_pkg::calc_req_t req,
  output vl2n_pkg::calc_rsp_t      rsp
);
  typedef enum logic [1:0] {IDLE, ROOT, DIV} state_t;
  state_t state;
  logic [vl2n_pkg::RadW-1:0]  rad;
  logic [vl2n_pkg::RootW+1:0] rem;
  logic [vl2n_pkg::RootW-1:0] root;
  logic [5:0]                 cnt;
  logic [vl2n_pkg::DenW-1:0]  den;
  logic [vl2n_pkg::DenW:0]    drem;
  logic [40:0]                quo;
  logic [vl2n_pkg::RootW+1:0] trial, rem_sh;
  logic [vl2n_pkg::DenW:0]    drem_sh;
  logic                       done;

  always_comb begin
    rem_sh  = {rem[vl2n_pkg::RootW-1:0], rad[vl2n_pkg::RadW-1 -: 2]};
    trial   = {root, 2'b01};
    drem_sh = {drem[vl2n_pkg::DenW-1:0], quo[40]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == DIV) && (cnt == 6'd0);
      unique case (state)
        IDLE: if (req.start) begin
          rad   <= {req.sum[vl2n_pkg::SumW-1:0], 16'b0};
          rem   <= '0;
          root  <= '0;
          cnt   <= 6'd31;
          state <= ROOT;
        end
        ROOT: begin
          rad <= rad << 2;
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[vl2n_pkg::RootW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[vl2n_pkg::RootW-2:0], 1'b0};
          end
          if (cnt == 6'd0) begin
            state <= DIV;
            cnt   <= 6'd40;
            drem  <= '0;
            quo   <= {1'b1, 40'b0};
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        DIV: begin
          if (cnt == 6'd40) den <= {1'b0, root} + vl2n_pkg::EpsQ16;
          else begin
            // restoring long division, one quotient bit per cycle
            if (drem_sh >= {1'b0, den}) begin
              drem <= drem_sh - {1'b0, den};
              quo  <= {quo[39:0], 1'b1};
            end else begin
              drem <= drem_sh;
              quo  <= {quo[39:0], 1'b0};
            end
          end
          if (cnt == 6'd40) begin
            drem <= '0;
            cnt  <= 6'd41;
          end
          if (cnt != 6'd40) begin
            if (cnt == 6'd0) state <= IDLE;
            else if (cnt == 6'd41) cnt <= 6'd39;
            else cnt <= cnt - 6'd1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // quotient shifted in during 41 steps; low 25 bits hold the scale
  assign rsp = '{done: done, scale: quo[vl2n_pkg::ScaleW-1:0]};
endmodule
`default_nettype wire

// ----- rtl/core/vector_l2_normalize_unit.sv -----
// ----------------------------------------------------------------------------
// vector_l2_normalize_unit
// buffers a vector, accumulates squares, then emits each element times scale
// ----------------------------------------------------------------------------
// path: last element transfer, start request, 32 root steps, divide steps,
//   scale load, memory read, output register, then first result valid
// throughput: in, one element per cycle while in LOAD; out, each element is
//   read, then registered, before the next read; m_axis_tready low holds the
//   output; no new vector is taken until the last result is registered
// reset: rst clears control, sum and count; the element memory is not cleared
`default_nettype none
module vector_l2_normalize_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] element
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] scaled_element
  output logic             m_axis_tlast
);
  typedef enum logic [1:0] {LOAD, CALC, EMIT} state_t;
  state_t state;
  logic [vl2n_pkg::ElemW-1:0]  mem [vl2n_pkg::StoreDepth];
  logic [vl2n_pkg::ElemW-1:0]  rd_data;
  logic [vl2n_pkg::SumW-1:0]   sum;
  logic [vl2n_pkg::CountW-1:0] count, rd_idx;
  logic [vl2n_pkg::ScaleW-1:0] scale;
  logic                        rd_valid, rd_last, busy;
  logic [15:0]                 mag_in, mag_rd;
  logic [40:0]                 prod;
  logic [15:0]                 q;
  logic                        in_acc;
  logic                        out_load;
  vl2n_pkg::calc_req_t         req;
  vl2n_pkg::calc_rsp_t         rsp;

  vl2n_scale_calc u_calc (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign s_axis_tready = (state == LOAD);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign mag_in = s_axis_tdata[15] ? 16'(-s_axis_tdata) : s_axis_tdata;
  assign mag_rd = rd_data[15] ? 16'(-rd_data) : rd_data;
  assign prod   = 41'(mag_rd) * 41'(scale);
  assign q      = prod[39:24];
  assign out_load = (state == EMIT) && rd_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (in_acc) mem[count[vl2n_pkg::AddrW-1:0]] <= s_axis_tdata;
    if (busy && !rd_valid) rd_data <= mem[rd_idx[vl2n_pkg::AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      sum <= '0;
      count <= '0;
      rd_valid <= 1'b0;
      busy <= 1'b0;
      m_axis_tvalid <= 1'b0;
      req.start <= 1'b0;
    end else begin
      req.start <= in_acc && (count == vl2n_pkg::CountW'(vl2n_pkg::VectorLen - 1));
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        LOAD: if (in_acc) begin
          if (count == vl2n_pkg::CountW'(vl2n_pkg::VectorLen - 1)) begin
            req.sum <= sum + vl2n_pkg::SumW'(32'(mag_in) * 32'(mag_in));
            state <= CALC;
          end else begin
            sum <= sum + vl2n_pkg::SumW'(32'(mag_in) * 32'(mag_in));
            count <= count + vl2n_pkg::CountW'(1);
          end
        end
        CALC: if (rsp.done) begin
          scale <= rsp.scale;
          rd_idx <= '0;
          busy <= 1'b1;
          rd_valid <= 1'b0;
          state <= EMIT;
        end
        EMIT: begin
          // read stage then output register, one element in flight
          if (busy && !rd_valid) begin
            rd_valid <= 1'b1;
            rd_last <= (rd_idx == vl2n_pkg::CountW'(vl2n_pkg::VectorLen - 1));
            rd_idx <= rd_idx + vl2n_pkg::CountW'(1);
          end else if (out_load) begin
            m_axis_tdata <= rd_data[15] ? 16'(-q) : q;
            m_axis_tlast <= rd_last;
            rd_valid <= 1'b0;
            if (rd_last) begin
              busy <= 1'b0;
              sum <= '0;
              count <= '0;
              state <= LOAD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire
